@@ src/dtq_pkg.sv @@
package dtq_pkg;

    localparam int DL_W  = 48;
    localparam int ID_W  = 32;
    localparam int TAG_W = 16;
    localparam int CNT7_W = 7;

    localparam logic [2:0] KIND_SCHEDULE   = 3'd0;
    localparam logic [2:0] KIND_CANCEL     = 3'd1;
    localparam logic [2:0] KIND_DISPATCH   = 3'd2;
    localparam logic [2:0] KIND_CANCEL_ALL = 3'd3;
    localparam logic [2:0] KIND_SHUTDOWN   = 3'd4;

    localparam logic [CNT7_W-1:0] CAPACITY_RESET = 7'd64;

    typedef struct packed {
        logic             valid;
        logic [DL_W-1:0]  deadline;
        logic [ID_W-1:0]  id;
        logic [TAG_W-1:0] tag;
    } entry_t;

    // Summary of one pass over the table.
    typedef struct packed {
        logic             best_found;
        logic [DL_W-1:0]  best_dl;
        logic [ID_W-1:0]  best_id;
        logic [TAG_W-1:0] best_tag;
        logic             second_found;
        logic [DL_W-1:0]  second_dl;
        logic             free_found;
        logic             match_found;
        logic             other_found;
        logic [DL_W-1:0]  other_dl;
    } scan_res_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_DECIDE,
        ST_OUT
    } state_t;

endpackage

@@ src/deadline_timer_queue_core.sv @@
// A schedule that is not refused, a cancel, and each step of a dispatch with a
// nonzero budget make one pass over the table memory before the result is valid;
// a dispatch firing n timers makes n passes, each starting when the previous result
// is taken. Cancel-all and shutdown sweep the table before answering; other items
// answer the next cycle. One item at a time: s_ready returns the cycle after the last
// result is taken. Reset zeroes the count, id counter and shutdown flag, sets the
// capacity to 64, and clears the table before s_ready rises.
module deadline_timer_queue_core
    import dtq_pkg::*;
#(
    parameter int MAX_TIMERS = 64,
    parameter int MAX_BUDGET = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CNT7_W-1:0]   cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_kind,
    input  logic [DL_W-1:0]     s_deadline,
    input  logic [TAG_W-1:0]    s_task_tag,
    input  logic [ID_W-1:0]     s_cancel_id,
    input  logic [DL_W-1:0]     s_now_time,
    input  logic [CNT7_W-1:0]   s_budget,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_done_ok,
    output logic                m_fired,
    output logic [ID_W-1:0]     m_task_id,
    output logic [TAG_W-1:0]    m_fired_tag,
    output logic [CNT7_W-1:0]   m_fired_count,
    output logic [CNT7_W-1:0]   m_pending_count,
    output logic                m_has_deadline,
    output logic [DL_W-1:0]     m_earliest_deadline,
    output logic                m_wake,
    output logic                m_bad_request,
    output logic                m_last
);

    localparam int AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CW = $clog2(MAX_TIMERS + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TIMERS - 1);

    state_t state_reg, state_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic              rvld_reg;
    logic [AW-1:0]     raddr_d_reg;
    logic [CNT7_W-1:0] cap_reg, cap_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [DL_W-1:0]   ear_reg, ear_next;
    logic [ID_W-1:0]   last_id_reg, last_id_next;
    logic              shut_reg, shut_next;
    logic              clr_rsp_reg, clr_rsp_next;

    logic [2:0]        kind_reg, kind_next;
    logic [DL_W-1:0]   dl_reg, dl_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [ID_W-1:0]   cid_reg, cid_next;
    logic [DL_W-1:0]   now_reg, now_next;
    logic [CNT7_W-1:0] bud_reg, bud_next;
    logic [CNT7_W-1:0] k_reg, k_next;

    logic              r_ok_reg, r_ok_next;
    logic              r_fired_reg, r_fired_next;
    logic [ID_W-1:0]   r_id_reg, r_id_next;
    logic [TAG_W-1:0]  r_tag_reg, r_tag_next;
    logic [CNT7_W-1:0] r_fcnt_reg, r_fcnt_next;
    logic [CNT7_W-1:0] r_pend_reg, r_pend_next;
    logic              r_has_reg, r_has_next;
    logic [DL_W-1:0]   r_ear_reg, r_ear_next;
    logic              r_wake_reg, r_wake_next;
    logic              r_bad_reg, r_bad_next;
    logic              r_last_reg, r_last_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    entry_t        mem_rdata;

    scan_res_t     sres;
    logic [AW-1:0] best_addr, free_addr, match_addr;
    logic          scan_start;

    logic [31:0]   cnt32, cap32, cap_eff;
    logic          full;
    logic          due;
    logic          more_due;
    logic [CNT7_W-1:0] bud_sat;

    dtq_mem #(
        .DEPTH (MAX_TIMERS),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (ptr_reg),
        .rdata (mem_rdata)
    );

    assign scan_start = (state_reg == ST_SCAN) && (ptr_reg == '0);

    dtq_scan #(
        .AW (AW)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (scan_start),
        .rd_vld     (rvld_reg),
        .rd_addr    (raddr_d_reg),
        .rd_data    (mem_rdata),
        .match_id   (cid_reg),
        .res        (sres),
        .best_addr  (best_addr),
        .free_addr  (free_addr),
        .match_addr (match_addr)
    );

    assign cnt32   = 32'(cnt_reg);
    assign cap32   = 32'(cap_reg);
    assign cap_eff = (cap32 == 32'd0) ? 32'd1 :
                     (cap32 > 32'(MAX_TIMERS)) ? 32'(MAX_TIMERS) : cap32;
    assign full    = cnt32 >= cap_eff;
    assign bud_sat = (32'(s_budget) > 32'(MAX_BUDGET)) ? CNT7_W'(MAX_BUDGET) : s_budget;
    assign due      = sres.best_found && (sres.best_dl <= now_reg);
    assign more_due = sres.second_found && (sres.second_dl <= now_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            ptr_reg     <= '0;
            rvld_reg    <= 1'b0;
            cap_reg     <= CAPACITY_RESET;
            cnt_reg     <= '0;
            ear_reg     <= '0;
            last_id_reg <= '0;
            shut_reg    <= 1'b0;
            clr_rsp_reg <= 1'b0;
            kind_reg    <= '0;
            k_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            rvld_reg    <= (state_reg == ST_SCAN);
            cap_reg     <= cap_next;
            cnt_reg     <= cnt_next;
            ear_reg     <= ear_next;
            last_id_reg <= last_id_next;
            shut_reg    <= shut_next;
            clr_rsp_reg <= clr_rsp_next;
            kind_reg    <= kind_next;
            k_reg       <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        raddr_d_reg <= ptr_reg;
        dl_reg      <= dl_next;
        tag_reg     <= tag_next;
        cid_reg     <= cid_next;
        now_reg     <= now_next;
        bud_reg     <= bud_next;
        r_ok_reg    <= r_ok_next;
        r_fired_reg <= r_fired_next;
        r_id_reg    <= r_id_next;
        r_tag_reg   <= r_tag_next;
        r_fcnt_reg  <= r_fcnt_next;
        r_pend_reg  <= r_pend_next;
        r_has_reg   <= r_has_next;
        r_ear_reg   <= r_ear_next;
        r_wake_reg  <= r_wake_next;
        r_bad_reg   <= r_bad_next;
        r_last_reg  <= r_last_next;
    end

    always_comb begin
        state_next   = state_reg;
        ptr_next     = '0;
        cap_next     = cfg_we ? cfg_wdata : cap_reg;
        cnt_next     = cnt_reg;
        ear_next     = ear_reg;
        last_id_next = last_id_reg;
        shut_next    = shut_reg;
        clr_rsp_next = clr_rsp_reg;
        kind_next    = kind_reg;
        dl_next      = dl_reg;
        tag_next     = tag_reg;
        cid_next     = cid_reg;
        now_next     = now_reg;
        bud_next     = bud_reg;
        k_next       = k_reg;
        r_ok_next    = r_ok_reg;
        r_fired_next = r_fired_reg;
        r_id_next    = r_id_reg;
        r_tag_next   = r_tag_reg;
        r_fcnt_next  = r_fcnt_reg;
        r_pend_next  = r_pend_reg;
        r_has_next   = r_has_reg;
        r_ear_next   = r_ear_reg;
        r_wake_next  = r_wake_reg;
        r_bad_next   = r_bad_reg;
        r_last_next  = r_last_reg;
        mem_we       = 1'b0;
        mem_waddr    = ptr_reg;
        mem_wdata    = '0;

        case (state_reg)
            ST_CLEAR: begin
                mem_we   = 1'b1;
                ptr_next = ptr_reg + AW'(1);
                if (ptr_reg == LAST_ADDR) begin
                    ptr_next     = '0;
                    clr_rsp_next = 1'b0;
                    state_next   = clr_rsp_reg ? ST_OUT : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    kind_next = s_kind;
                    dl_next   = s_deadline;
                    tag_next  = s_task_tag;
                    cid_next  = s_cancel_id;
                    now_next  = s_now_time;
                    bud_next  = bud_sat;
                    k_next    = '0;
                    // Default result: nothing done, state reported as it stands.
                    r_ok_next    = 1'b0;
                    r_fired_next = 1'b0;
                    r_id_next    = '0;
                    r_tag_next   = '0;
                    r_fcnt_next  = '0;
                    r_pend_next  = CNT7_W'(cnt_reg);
                    r_has_next   = (cnt_reg != '0);
                    r_ear_next   = (cnt_reg != '0) ? ear_reg : '0;
                    r_wake_next  = 1'b0;
                    r_bad_next   = 1'b0;
                    r_last_next  = 1'b1;
                    state_next   = ST_OUT;
                    case (s_kind)
                        KIND_SCHEDULE: begin
                            if (!(shut_reg || full || (last_id_reg == '1))) begin
                                state_next = ST_SCAN;
                            end
                        end
                        KIND_CANCEL: begin
                            state_next = ST_SCAN;
                        end
                        KIND_DISPATCH: begin
                            if (s_budget == '0) begin
                                r_bad_next = 1'b1;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        KIND_CANCEL_ALL, KIND_SHUTDOWN: begin
                            r_ok_next    = 1'b1;
                            r_wake_next  = (s_kind == KIND_CANCEL_ALL) || !shut_reg;
                            r_pend_next  = '0;
                            r_has_next   = 1'b0;
                            r_ear_next   = '0;
                            cnt_next     = '0;
                            clr_rsp_next = 1'b1;
                            if (s_kind == KIND_SHUTDOWN) begin
                                shut_next = 1'b1;
                            end
                            state_next = ST_CLEAR;
                        end
                        default: begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                ptr_next = ptr_reg + AW'(1);
                if (ptr_reg == LAST_ADDR) begin
                    ptr_next   = '0;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                state_next = ST_OUT;
                case (kind_reg)
                    KIND_SCHEDULE: begin
                        mem_we       = 1'b1;
                        mem_waddr    = free_addr;
                        mem_wdata    = '{valid: 1'b1, deadline: dl_reg,
                                         id: last_id_reg + ID_W'(1), tag: tag_reg};
                        last_id_next = last_id_reg + ID_W'(1);
                        cnt_next     = cnt_reg + CW'(1);
                        ear_next     = ((cnt_reg == '0) || (dl_reg < ear_reg)) ? dl_reg : ear_reg;
                        r_ok_next    = 1'b1;
                        r_id_next    = last_id_reg + ID_W'(1);
                        r_wake_next  = 1'b1;
                        r_pend_next  = CNT7_W'(cnt_reg + CW'(1));
                        r_has_next   = 1'b1;
                        r_ear_next   = ((cnt_reg == '0) || (dl_reg < ear_reg)) ? dl_reg : ear_reg;
                    end
                    KIND_CANCEL: begin
                        if (sres.match_found) begin
                            mem_we      = 1'b1;
                            mem_waddr   = match_addr;
                            cnt_next    = cnt_reg - CW'(1);
                            ear_next    = sres.other_dl;
                            r_ok_next   = 1'b1;
                            r_wake_next = 1'b1;
                            r_pend_next = CNT7_W'(cnt_reg - CW'(1));
                            r_has_next  = sres.other_found;
                            r_ear_next  = sres.other_found ? sres.other_dl : '0;
                        end
                    end
                    KIND_DISPATCH: begin
                        r_ok_next = 1'b1;
                        if (due) begin
                            mem_we       = 1'b1;
                            mem_waddr    = best_addr;
                            cnt_next     = cnt_reg - CW'(1);
                            ear_next     = sres.second_dl;
                            k_next       = k_reg + CNT7_W'(1);
                            r_fired_next = 1'b1;
                            r_id_next    = sres.best_id;
                            r_tag_next   = sres.best_tag;
                            r_fcnt_next  = k_reg + CNT7_W'(1);
                            r_pend_next  = CNT7_W'(cnt_reg - CW'(1));
                            r_has_next   = sres.second_found;
                            r_ear_next   = sres.second_found ? sres.second_dl : '0;
                            r_last_next  = ((k_reg + CNT7_W'(1)) == bud_reg) || !more_due;
                        end
                    end
                    default: begin
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_OUT: begin
                if (m_ready) begin
                    // Another firing of the same dispatch starts a fresh pass.
                    state_next = ((kind_reg == KIND_DISPATCH) && !r_last_reg) ? ST_SCAN : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready             = (state_reg == ST_IDLE);
    assign m_valid             = (state_reg == ST_OUT);
    assign m_done_ok           = r_ok_reg;
    assign m_fired             = r_fired_reg;
    assign m_task_id           = r_id_reg;
    assign m_fired_tag         = r_tag_reg;
    assign m_fired_count       = r_fcnt_reg;
    assign m_pending_count     = r_pend_reg;
    assign m_has_deadline      = r_has_reg;
    assign m_earliest_deadline = r_ear_reg;
    assign m_wake              = r_wake_reg;
    assign m_bad_request       = r_bad_reg;
    assign m_last              = r_last_reg;

endmodule

@@ src/dtq_mem.sv @@
module dtq_mem
    import dtq_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/dtq_scan.sv @@
module dtq_scan
    import dtq_pkg::*;
#(
    parameter int AW = 6
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic            rd_vld,
    input  logic [AW-1:0]   rd_addr,
    input  entry_t          rd_data,
    input  logic [ID_W-1:0] match_id,
    output scan_res_t       res,
    output logic [AW-1:0]   best_addr,
    output logic [AW-1:0]   free_addr,
    output logic [AW-1:0]   match_addr
);

    scan_res_t     res_reg;
    logic [AW-1:0] best_addr_reg;
    logic [AW-1:0] free_addr_reg;
    logic [AW-1:0] match_addr_reg;
    logic          better;

    assign better = !res_reg.best_found || (rd_data.deadline < res_reg.best_dl) ||
                    ((rd_data.deadline == res_reg.best_dl) && (rd_data.id < res_reg.best_id));

    always_ff @(posedge aclk) begin
        if (!aresetn || start) begin
            res_reg.best_found   <= 1'b0;
            res_reg.second_found <= 1'b0;
            res_reg.free_found   <= 1'b0;
            res_reg.match_found  <= 1'b0;
            res_reg.other_found  <= 1'b0;
        end else if (rd_vld) begin
            if (rd_data.valid) begin
                if (better) begin
                    res_reg.best_found <= 1'b1;
                    res_reg.best_dl    <= rd_data.deadline;
                    res_reg.best_id    <= rd_data.id;
                    res_reg.best_tag   <= rd_data.tag;
                    best_addr_reg      <= rd_addr;
                    // The displaced best is never later than the old runner-up.
                    if (res_reg.best_found) begin
                        res_reg.second_found <= 1'b1;
                        res_reg.second_dl    <= res_reg.best_dl;
                    end
                end else if (!res_reg.second_found || rd_data.deadline < res_reg.second_dl) begin
                    res_reg.second_found <= 1'b1;
                    res_reg.second_dl    <= rd_data.deadline;
                end
                if (rd_data.id == match_id) begin
                    res_reg.match_found <= 1'b1;
                    match_addr_reg      <= rd_addr;
                end else if (!res_reg.other_found || rd_data.deadline < res_reg.other_dl) begin
                    res_reg.other_found <= 1'b1;
                    res_reg.other_dl    <= rd_data.deadline;
                end
            end else if (!res_reg.free_found) begin
                res_reg.free_found <= 1'b1;
                free_addr_reg      <= rd_addr;
            end
        end
    end

    assign res        = res_reg;
    assign best_addr  = best_addr_reg;
    assign free_addr  = free_addr_reg;
    assign match_addr = match_addr_reg;

endmodule

@@ tb/sv/tb_deadline_timer_queue_core.sv @@
`timescale 1ns / 1ps

module tb_deadline_timer_queue_core;
    import dtq_pkg::*;

    localparam int  NUM_SLOTS   = 64;
    localparam int  BUDGET_CAP  = 64;
    localparam int  CYCLE_LIMIT = 5000000;
    localparam int  HOLD_CYCLES = 300;
    localparam logic [2:0] KIND_BAD5 = 3'd5;
    localparam logic [2:0] KIND_BAD6 = 3'd6;
    localparam logic [2:0] KIND_BAD7 = 3'd7;
    localparam logic [DL_W-1:0] DL_MAX = '1;
    localparam logic [ID_W-1:0] ID_MAX = '1;

    typedef struct {
        logic [2:0]        kind;
        logic [DL_W-1:0]   deadline;
        logic [TAG_W-1:0]  tag;
        logic [ID_W-1:0]   cancel_id;
        logic [DL_W-1:0]   now_time;
        logic [CNT7_W-1:0] budget;
    } timer_op_t;

    typedef struct {
        logic              done_ok;
        logic              fired;
        logic [ID_W-1:0]   task_id;
        logic [TAG_W-1:0]  fired_tag;
        logic [CNT7_W-1:0] fired_count;
        logic [CNT7_W-1:0] pending_count;
        logic              has_deadline;
        logic [DL_W-1:0]   earliest_deadline;
        logic              wake;
        logic              bad_request;
        logic              last;
    } timer_res_t;

    class timer_scoreboard;
        bit                slot_busy[NUM_SLOTS];
        logic [DL_W-1:0]   slot_dl[NUM_SLOTS];
        logic [ID_W-1:0]   slot_id[NUM_SLOTS];
        logic [TAG_W-1:0]  slot_tag[NUM_SLOTS];
        logic [ID_W-1:0]   last_id;
        bit                is_shut;
        logic [CNT7_W-1:0] capacity;
        timer_res_t        expected_q[$];

        function new();
            foreach (slot_busy[i]) slot_busy[i] = 0;
            last_id  = '0;
            is_shut  = 0;
            capacity = CAPACITY_RESET;
        endfunction

        function int count_busy();
            int n;
            n = 0;
            foreach (slot_busy[i]) if (slot_busy[i]) n++;
            return n;
        endfunction

        // Earliest deadline first, lower id on a tie; -1 when the table is empty.
        function int earliest_slot();
            int b;
            b = -1;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (!slot_busy[i]) continue;
                if (b < 0 || slot_dl[i] < slot_dl[b] ||
                    (slot_dl[i] == slot_dl[b] && slot_id[i] < slot_id[b]))
                    b = i;
            end
            return b;
        endfunction

        function void add_result(bit ok, bit fired, logic [ID_W-1:0] id,
                                 logic [TAG_W-1:0] tag, int fcount, bit wake,
                                 bit bad, bit last);
            timer_res_t r;
            int e;
            e = earliest_slot();
            r.done_ok           = ok;
            r.fired             = fired;
            r.task_id           = id;
            r.fired_tag         = tag;
            r.fired_count       = fcount[CNT7_W-1:0];
            r.pending_count     = CNT7_W'(count_busy());
            r.has_deadline      = (e >= 0);
            r.earliest_deadline = (e >= 0) ? slot_dl[e] : '0;
            r.wake              = wake;
            r.bad_request       = bad;
            r.last              = last;
            expected_q = {expected_q, r};
        endfunction

        function void note_item(timer_op_t op);
            int cap_eff, free_slot, nfire, b, e;
            bit found;
            case (op.kind)
                KIND_SCHEDULE: begin
                    cap_eff = (capacity == 0) ? 1 : (capacity > NUM_SLOTS) ? NUM_SLOTS
                                                                          : capacity;
                    free_slot = -1;
                    for (int i = 0; i < NUM_SLOTS; i++)
                        if (!slot_busy[i] && free_slot < 0) free_slot = i;
                    if (is_shut || count_busy() >= cap_eff || free_slot < 0 ||
                        last_id == ID_MAX) begin
                        add_result(0, 0, '0, '0, 0, 0, 0, 1);
                    end else begin
                        last_id++;
                        slot_busy[free_slot] = 1;
                        slot_dl[free_slot]   = op.deadline;
                        slot_id[free_slot]   = last_id;
                        slot_tag[free_slot]  = op.tag;
                        add_result(1, 0, last_id, '0, 0, 1, 0, 1);
                    end
                end
                KIND_CANCEL: begin
                    found = 0;
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (!found && slot_busy[i] && slot_id[i] == op.cancel_id) begin
                            slot_busy[i] = 0;
                            found = 1;
                        end
                    end
                    add_result(found, 0, '0, '0, 0, found, 0, 1);
                end
                KIND_DISPATCH: begin
                    if (op.budget == 0) begin
                        add_result(0, 0, '0, '0, 0, 0, 1, 1);
                    end else begin
                        b = (op.budget > BUDGET_CAP) ? BUDGET_CAP : op.budget;
                        nfire = 0;
                        while (nfire < b) begin
                            e = earliest_slot();
                            if (e < 0 || slot_dl[e] > op.now_time) break;
                            slot_busy[e] = 0;
                            nfire++;
                            add_result(1, 1, slot_id[e], slot_tag[e], nfire, 0, 0, 0);
                        end
                        if (nfire == 0)
                            add_result(1, 0, '0, '0, 0, 0, 0, 1);
                        else
                            expected_q[expected_q.size()-1].last = 1;
                    end
                end
                KIND_CANCEL_ALL: begin
                    foreach (slot_busy[i]) slot_busy[i] = 0;
                    add_result(1, 0, '0, '0, 0, 1, 0, 1);
                end
                KIND_SHUTDOWN: begin
                    found = !is_shut;
                    is_shut = 1;
                    foreach (slot_busy[i]) slot_busy[i] = 0;
                    add_result(1, 0, '0, '0, 0, found, 0, 1);
                end
                default: add_result(0, 0, '0, '0, 0, 0, 0, 1);
            endcase
        endfunction

        // Returns an empty string when the result matches the oldest expectation.
        function string check_result(timer_res_t got);
            timer_res_t w;
            string s;
            if (expected_q.size() == 0) return "result arrived with nothing expected";
            w = expected_q.pop_front();
            s = "";
            if (got.done_ok !== w.done_ok)
                s = {s, $sformatf(" done_ok %0d/%0d", got.done_ok, w.done_ok)};
            if (got.fired !== w.fired)
                s = {s, $sformatf(" fired %0d/%0d", got.fired, w.fired)};
            if (got.task_id !== w.task_id)
                s = {s, $sformatf(" task_id %0d/%0d", got.task_id, w.task_id)};
            if (got.fired_tag !== w.fired_tag)
                s = {s, $sformatf(" fired_tag %h/%h", got.fired_tag, w.fired_tag)};
            if (got.fired_count !== w.fired_count)
                s = {s, $sformatf(" fired_count %0d/%0d", got.fired_count, w.fired_count)};
            if (got.pending_count !== w.pending_count)
                s = {s, $sformatf(" pending %0d/%0d", got.pending_count, w.pending_count)};
            if (got.has_deadline !== w.has_deadline)
                s = {s, $sformatf(" has_dl %0d/%0d", got.has_deadline, w.has_deadline)};
            if (got.earliest_deadline !== w.earliest_deadline)
                s = {s, $sformatf(" earliest %h/%h", got.earliest_deadline,
                                  w.earliest_deadline)};
            if (got.wake !== w.wake)
                s = {s, $sformatf(" wake %0d/%0d", got.wake, w.wake)};
            if (got.bad_request !== w.bad_request)
                s = {s, $sformatf(" bad_request %0d/%0d", got.bad_request, w.bad_request)};
            if (got.last !== w.last)
                s = {s, $sformatf(" last %0d/%0d", got.last, w.last)};
            return s;
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CNT7_W-1:0] cfg_wdata = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [2:0]        s_kind = '0;
    logic [DL_W-1:0]   s_deadline = '0;
    logic [TAG_W-1:0]  s_task_tag = '0;
    logic [ID_W-1:0]   s_cancel_id = '0;
    logic [DL_W-1:0]   s_now_time = '0;
    logic [CNT7_W-1:0] s_budget = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_done_ok, m_fired, m_has_deadline, m_wake, m_bad_request, m_last;
    logic [ID_W-1:0]   m_task_id;
    logic [TAG_W-1:0]  m_fired_tag;
    logic [CNT7_W-1:0] m_fired_count, m_pending_count;
    logic [DL_W-1:0]   m_earliest_deadline;

    timer_scoreboard sb = new();
    int  error_count = 0;
    int  cycle_count = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_req = 0;
    int  hold_left = 0;

    always #5 aclk = ~aclk;

    deadline_timer_queue_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_deadline(s_deadline), .s_task_tag(s_task_tag), .s_cancel_id(s_cancel_id),
        .s_now_time(s_now_time), .s_budget(s_budget),
        .m_valid(m_valid), .m_ready(m_ready), .m_done_ok(m_done_ok), .m_fired(m_fired),
        .m_task_id(m_task_id), .m_fired_tag(m_fired_tag), .m_fired_count(m_fired_count),
        .m_pending_count(m_pending_count), .m_has_deadline(m_has_deadline),
        .m_earliest_deadline(m_earliest_deadline), .m_wake(m_wake),
        .m_bad_request(m_bad_request), .m_last(m_last)
    );

    task automatic report(input string msg);
        $display("mismatch at cycle %0d:%s", cycle_count, msg);
        error_count++;
    endtask

    // The receiver honors a long hold-off request before going back to random stalls.
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 0;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        timer_res_t got;
        string msg;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_done_ok, m_fired, m_task_id, m_fired_tag, m_fired_count,
                    m_pending_count, m_has_deadline, m_earliest_deadline, m_wake,
                    m_bad_request, m_last};
            msg = sb.check_result(got);
            if (msg != "") report(msg);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic timer_op_t make_op(logic [2:0] kind, logic [DL_W-1:0] dl,
                                          logic [TAG_W-1:0] tag, logic [ID_W-1:0] cid,
                                          logic [DL_W-1:0] now, logic [CNT7_W-1:0] budget);
        timer_op_t op;
        op.kind = kind; op.deadline = dl; op.tag = tag;
        op.cancel_id = cid; op.now_time = now; op.budget = budget;
        return op;
    endfunction

    // Mostly small deadlines and times so that dispatches find due timers.
    function automatic timer_op_t random_op();
        timer_op_t op;
        int r;
        r = $urandom_range(99);
        op = make_op(KIND_SCHEDULE, DL_W'({$urandom, $urandom}), TAG_W'($urandom), $urandom,
                     DL_W'({$urandom, $urandom}), CNT7_W'($urandom));
        if ($urandom_range(9) != 0) op.deadline = DL_W'($urandom_range(1000));
        if ($urandom_range(9) != 0) op.now_time = DL_W'($urandom_range(1200));
        if ($urandom_range(9) != 0) op.cancel_id = sb.last_id - $urandom_range(8);
        if ($urandom_range(9) != 0) op.budget = CNT7_W'($urandom_range(1, 4));
        else if ($urandom_range(1) == 0) op.budget = '0;
        if (r < 45)      op.kind = KIND_SCHEDULE;
        else if (r < 62) op.kind = KIND_CANCEL;
        else if (r < 90) op.kind = KIND_DISPATCH;
        else if (r < 95) op.kind = KIND_CANCEL_ALL;
        else             op.kind = 3'($urandom_range(5, 7));
        return op;
    endfunction

    // Called at a falling edge; returns at a falling edge after acceptance.
    task automatic send_item(input timer_op_t op);
        s_valid     = 1'b1;
        s_kind      = op.kind;
        s_deadline  = op.deadline;
        s_task_tag  = op.tag;
        s_cancel_id = op.cancel_id;
        s_now_time  = op.now_time;
        s_budget    = op.budget;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(op);
        @(negedge aclk);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 80 : 4)) @(negedge aclk);
        end
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (sb.expected_q.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    task automatic set_capacity(input logic [CNT7_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        sb.capacity = value;
    endtask

    initial begin
        int idle_pct[4]  = '{0, 62, 0, 30};
        int stall_pct[4] = '{0, 0, 62, 30};
        logic [CNT7_W-1:0] caps[4] = '{7'd127, 7'd5, 7'd0, 7'd64};

        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        // Table clear after reset: nothing goes in until the input is ready.
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);

        // Directed: field extremes, tie on deadline, misses, zero and oversized budgets.
        send_item(make_op(KIND_SCHEDULE, '0, '0, '0, '0, '0));
        send_item(make_op(KIND_SCHEDULE, DL_MAX, 16'hffff, ID_MAX, DL_MAX, 7'h7f));
        send_item(make_op(KIND_SCHEDULE, 48'd5, 16'h1234, '0, '0, '0));
        send_item(make_op(KIND_SCHEDULE, 48'd5, 16'h4321, '0, '0, '0));
        send_item(make_op(KIND_CANCEL, '0, '0, '0, '0, '0));
        send_item(make_op(KIND_CANCEL, '0, '0, ID_MAX, '0, '0));
        send_item(make_op(KIND_CANCEL, '0, '0, 32'd3, '0, '0));
        send_item(make_op(KIND_DISPATCH, '0, '0, '0, DL_MAX, '0));
        send_item(make_op(KIND_DISPATCH, '0, '0, '0, '0, 7'h7f));
        send_item(make_op(KIND_DISPATCH, '0, '0, '0, 48'd4, 7'd1));
        send_item(make_op(KIND_DISPATCH, '0, '0, '0, 48'd10, 7'd1));
        send_item(make_op(KIND_DISPATCH, '0, '0, '0, DL_MAX, 7'd64));
        send_item(make_op(KIND_BAD5, '0, '0, '0, '0, '0));
        send_item(make_op(KIND_BAD6, DL_MAX, '1, '1, DL_MAX, '1));
        send_item(make_op(KIND_BAD7, '0, '0, '0, '0, '0));
        send_item(make_op(KIND_SCHEDULE, 48'd7, 16'h00ff, '0, '0, '0));
        send_item(make_op(KIND_CANCEL_ALL, '0, '0, '0, '0, '0));
        drain();
        // A limit of one refuses the second schedule.
        set_capacity(7'd1);
        send_item(make_op(KIND_SCHEDULE, 48'd9, 16'h0f0f, '0, '0, '0));
        send_item(make_op(KIND_SCHEDULE, 48'd9, 16'hf0f0, '0, '0, '0));
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_pct[ph];
            recv_stall_pct = stall_pct[ph];
            set_capacity(caps[ph]);
            if (ph == 0) begin
                // Results are held back while schedules keep coming, so the input stalls.
                hold_req = 1;
                repeat (12) send_item(make_op(KIND_SCHEDULE, DL_W'($urandom_range(300)),
                                              TAG_W'($urandom), '0, '0, '0));
            end
            repeat (19) send_item(random_op());
            drain();
        end

        // Shutdown refuses every later schedule; a second one gives no wake.
        send_item(make_op(KIND_SCHEDULE, 48'd3, 16'h5555, '0, '0, '0));
        send_item(make_op(KIND_SHUTDOWN, '0, '0, '0, '0, '0));
        send_item(make_op(KIND_SCHEDULE, 48'd3, 16'haaaa, '0, '0, '0));
        send_item(make_op(KIND_SHUTDOWN, '0, '0, '0, '0, '0));
        send_item(make_op(KIND_DISPATCH, '0, '0, '0, DL_MAX, 7'd2));
        drain();
        repeat (80) @(negedge aclk);

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
